/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, held off while reset is high.
`define NAT_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that is active during reset as well.
`define NAT_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/nat_pkg.sv */
// Package for the nanosecond alarm timer: mode codes, field widths, constants
// and the stage struct. No dependencies.
package nat_pkg;

  localparam int MODE_W = 3;
  localparam int TSEC_W = 32;
  localparam int NS_W   = 30;
  localparam int STEP_W = 20;
  // seconds * 1e9 + nanoseconds always fits in 62 bits
  localparam int SPAN_W = 62;

  localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_READ   = 3'd1,
    MODE_CANCEL = 3'd2,
    MODE_ABS    = 3'd3,
    MODE_REL    = 3'd4
  } mode_t;

  // Request after the span multiply, as handed to the state stage
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SPAN_W-1:0] span;
  } span_stage_t;

endpackage

/* rtl/nat_if.sv */
// Request and response channel interfaces of the nanosecond alarm timer.
// Depends on nat_pkg.
interface nat_req_if;
  import nat_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TSEC_W-1:0] time_seconds;
  logic [NS_W-1:0]   time_nanoseconds;

  modport source (output valid, mode, time_seconds, time_nanoseconds, input ready);
  modport sink   (input valid, mode, time_seconds, time_nanoseconds, output ready);
endinterface

interface nat_rsp_if;
  import nat_pkg::*;
  logic              valid;
  logic              ready;
  logic [TSEC_W-1:0] now_seconds;
  logic [NS_W-1:0]   now_nanoseconds;
  logic              alarm_fired;

  modport source (output valid, now_seconds, now_nanoseconds, alarm_fired, input ready);
  modport sink   (input valid, now_seconds, now_nanoseconds, alarm_fired, output ready);
endinterface

/* rtl/nat_span.sv */
// Input register and span multiply stage (seconds * 1e9 + nanoseconds).
// Depends on nat_pkg and nat_req_if.
module nat_span (
  input  logic                clk,
  input  logic                rst,
  nat_req_if.sink             req,
  output logic                out_valid,
  input  logic                out_ready,
  output nat_pkg::span_stage_t out_data
);
  import nat_pkg::*;

  logic              a_valid;
  logic [MODE_W-1:0] a_mode;
  logic [TSEC_W-1:0] a_sec;
  logic [NS_W-1:0]   a_ns;
  logic              a_ready;
  logic              b_ready;
  logic [SPAN_W-1:0] span_c;

  assign b_ready   = !out_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req.ready = a_ready;

  // 32 x 30 constant multiply, then the nanoseconds added
  assign span_c = SPAN_W'(a_sec) * SPAN_W'(NS_PER_SEC) + SPAN_W'(a_ns);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && req.valid) begin
      a_mode <= req.mode;
      a_sec  <= req.time_seconds;
      a_ns   <= req.time_nanoseconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_data.mode <= a_mode;
      out_data.span <= span_c;
    end
  end

endmodule

/* rtl/nat_core.sv */
// Timer state (counter, split seconds/nanoseconds, alarm, step) and the
// response register. Depends on nat_pkg and nat_rsp_if.
module nat_core #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [nat_pkg::STEP_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nat_pkg::span_stage_t       in_data,
  nat_rsp_if.source                  rsp
);
  import nat_pkg::*;

  // counter / 1e9 never needs more than COUNTER_WIDTH - 29 bits
  localparam int SEC_W = COUNTER_WIDTH - 29;

  logic [COUNTER_WIDTH-1:0] counter, counter_next;
  logic [COUNTER_WIDTH-1:0] alarm, alarm_next;
  logic [SEC_W-1:0]         sec, sec_next;
  logic [NS_W-1:0]          ns, ns_next;
  logic [STEP_W-1:0]        step;
  logic [COUNTER_WIDTH:0]   tick_sum;
  logic [NS_W:0]            ns_sum;
  logic                     fired;
  logic                     fire;

  assign in_ready = !rsp.valid || rsp.ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    tick_sum     = {1'b0, counter} + (COUNTER_WIDTH + 1)'(step);
    ns_sum       = {1'b0, ns} + (NS_W + 1)'(step);
    counter_next = counter;
    alarm_next   = alarm;
    sec_next     = sec;
    ns_next      = ns;
    fired        = 1'b0;
    unique case (mode_t'(in_data.mode))
      MODE_TICK: begin
        counter_next = tick_sum[COUNTER_WIDTH-1:0];
        if (tick_sum[COUNTER_WIDTH]) begin
          // wrapped: new count is below the step, so below one second
          sec_next = '0;
          ns_next  = NS_W'(tick_sum[COUNTER_WIDTH-1:0]);
        end else if (ns_sum >= {1'b0, NS_PER_SEC}) begin
          ns_next  = NS_W'(ns_sum - {1'b0, NS_PER_SEC});
          sec_next = sec + SEC_W'(1);
        end else begin
          ns_next = ns_sum[NS_W-1:0];
        end
        fired = (alarm != '0) && (counter_next >= alarm);
      end
      MODE_CANCEL: alarm_next = '0;
      MODE_ABS:    alarm_next = COUNTER_WIDTH'(in_data.span);
      MODE_REL:    alarm_next = counter + COUNTER_WIDTH'(in_data.span);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      alarm   <= '0;
      sec     <= '0;
      ns      <= '0;
    end else if (fire) begin
      counter <= counter_next;
      alarm   <= alarm_next;
      sec     <= sec_next;
      ns      <= ns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (in_ready) begin
      rsp.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.now_seconds     <= TSEC_W'(sec_next);
      rsp.now_nanoseconds <= ns_next;
      rsp.alarm_fired     <= fired;
    end
  end

endmodule

/* rtl/nanosecond_alarm_timer.sv */
// Nanosecond alarm timer, top level. Uses nat_pkg, nat_if, nat_span, nat_core.
// Path: the input register loads on the accepting edge, then the span
// register, then the response register, which drives the response.
// Throughput: one request per cycle while the response is taken; the 32 x 30
// span multiply and the 64-bit tick add/compare each sit in their own stage.
// Reset (rst, synchronous): time and alarm cleared, step back to 1000 ns.
module nanosecond_alarm_timer #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [nat_pkg::STEP_W-1:0] cfg_wr_data,
  nat_req_if.sink                    req,
  nat_rsp_if.source                  rsp
);
  import nat_pkg::*;

  // Span stage to state stage. Each stage has its own valid and
  // takes a new request whenever it is empty or the next one moves, so the
  // front fills any empty stage while a finished response waits at the output.
  logic        span_valid;
  logic        span_ready;
  span_stage_t span_data;

  // Stages 1-2: register the request, form seconds * 1e9 + nanoseconds.
  // This has no dependence on timer state, so it runs ahead freely.
  nat_span u_span (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (span_valid),
    .out_ready (span_ready),
    .out_data  (span_data)
  );

  // Stage 3: all state lives here. The counter is kept alongside a
  // seconds/nanoseconds split that is stepped with it, so no divider is
  // needed for the response; a wrap of the counter restarts the split.
  nat_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (span_valid),
    .in_ready    (span_ready),
    .in_data     (span_data),
    .rsp         (rsp)
  );

endmodule

/* rtl/nat_checker.sv */
// Port-level checks for the nanosecond alarm timer, bound to the top level.
// Depends on nat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nat_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [nat_pkg::TSEC_W-1:0] rsp_now_seconds,
  input logic [nat_pkg::NS_W-1:0]   rsp_now_nanoseconds,
  input logic                       rsp_alarm_fired
);
  import nat_pkg::*;

  logic                         rsp_stall;
  logic [TSEC_W+NS_W:0]         rsp_payload;
  logic                         ns_ok;

  assign rsp_stall   = rsp_valid && !rsp_ready;
  assign rsp_payload = {rsp_now_seconds, rsp_now_nanoseconds, rsp_alarm_fired};
  assign ns_ok       = rsp_now_nanoseconds < NS_PER_SEC;

  `NAT_ASSERT(a_reset_idle, clk, rst |=> !rsp_valid, "response valid after reset")
  `NAT_ASSERT_RST(a_rsp_hold, clk, rst, rsp_stall |=> rsp_valid, "response dropped")
  `NAT_ASSERT_RST(a_rsp_stable, clk, rst, rsp_stall |=> $stable(rsp_payload), "response changed")
  `NAT_ASSERT_RST(a_ns_range, clk, rst, rsp_valid |-> ns_ok, "nanoseconds out of range")
  `NAT_ASSERT_RST(a_skid_ready, clk, rst, !rsp_valid |-> req_ready, "blocked with output empty")

endmodule

bind nanosecond_alarm_timer nat_checker u_nat_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_now_seconds     (rsp.now_seconds),
  .rsp_now_nanoseconds (rsp.now_nanoseconds),
  .rsp_alarm_fired     (rsp.alarm_fired)
);
